### design/dtf_pkg.sv
// ----------------------------------------------------------------------------
// dtf_pkg: shared types and constants for the decimal text parser
// Field widths, character codes, the power-of-ten table and the state types.
// ----------------------------------------------------------------------------
package dtf_pkg;

  localparam int INT_BITS        = 31;
  localparam int FRAC_BITS       = 16;
  localparam int MAX_FRAC_DIGITS = 9;
  localparam int VALUE_W         = 48;
  localparam int CH_W            = 8;

  function automatic logic [63:0] pow10_64(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  localparam int FRAC_ACC_W = $clog2(pow10_64(MAX_FRAC_DIGITS));
  localparam int FCNT_W     = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int SRC_W      = (INT_BITS > FRAC_ACC_W) ? INT_BITS : FRAC_ACC_W;
  localparam int ALU_W      = SRC_W + 4;
  localparam int IT_W       = $clog2(FRAC_BITS + 1);

  typedef logic [FRAC_ACC_W-1:0] pow_tbl_t [MAX_FRAC_DIGITS+1];

  function automatic pow_tbl_t mk_pow_tbl();
    pow_tbl_t t;
    for (int i = 0; i <= MAX_FRAC_DIGITS; i++) begin
      t[i] = FRAC_ACC_W'(pow10_64(i));
    end
    return t;
  endfunction

  localparam pow_tbl_t POW10 = mk_pow_tbl();

  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  localparam logic [VALUE_W-1:0] MAG_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] NEG_MAX = VAL_MIN | VALUE_W'(1);

  typedef enum logic [2:0] {
    PH_START,
    PH_MINUS,
    PH_INT,
    PH_FRAC,
    PH_SKIP
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            has_char;
    logic            last;
  } dtf_in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;
  } dtf_out_t;

endpackage

### design/decimal_text_to_fixed.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed: decimal string to signed Q31.16
// At most one character per transaction; the last transaction yields one result.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  in      | in  | in_valid_i / in_ready_o  | in_data_i  (dtf_in_t)
//  out     | out | out_valid_o / out_ready_i| out_data_o (dtf_out_t)
//
//  Each character is accepted, then takes one pass through the shared add
//  unit (times ten plus digit). The last character adds FRAC_BITS + 1
//  restoring-division steps on the same unit, then a compose and an output
//  step. Reset clears the sequencer and the accumulators. A stalled output
//  holds the sequencer in its output state.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed import dtf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dtf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dtf_out_t out_data_o
);

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic        ovf_q, ovf_d;
  logic [INT_BITS-1:0]   int_q, int_d;
  logic [FRAC_ACC_W-1:0] frac_q, frac_d;
  logic [FCNT_W-1:0]     fcnt_q, fcnt_d;
  logic [CH_W-1:0]       ch_q, ch_d;
  logic                  has_q, has_d;
  logic                  last_q, last_d;
  logic [FRAC_BITS-1:0]  quo_q, quo_d;
  logic                  rnd_q, rnd_d;
  logic [IT_W-1:0]       it_q, it_d;
  logic [VALUE_W-1:0]    mag_q, mag_d;
  logic                  sat_q, sat_d;
  logic                  out_valid_q, out_valid_d;
  dtf_out_t              out_q, out_d;

  logic                  in_acc;
  logic                  out_free;
  logic                  is_dig;
  logic [3:0]            dval;
  logic [SRC_W-1:0]      src;
  logic [ALU_W-1:0]      alu_a, alu_b;
  logic [3:0]            alu_c;
  logic [ALU_W:0]        alu_sum;
  logic                  carry;
  logic [FRAC_ACC_W-1:0] pw;
  logic [VALUE_W-1:0]    comp;
  logic                  big;

  // control outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    in_acc     = in_valid_i && in_ready_o;
    out_free   = !out_valid_q || out_ready_i;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_STEP;
      ST_STEP: state_d = last_q ? ST_DIV : ST_IDLE;
      ST_DIV:  if (it_q == IT_W'(FRAC_BITS)) state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign is_dig = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign dval   = 4'(ch_q - CH_ZERO);
  assign src    = (phase_q == PH_FRAC) ? SRC_W'(frac_q) : SRC_W'(int_q);
  assign pw     = POW10[fcnt_q];

  // shared adder: x*10 + d while parsing, r*2 - pw while dividing
  always_comb begin
    if (state_q == ST_DIV) begin
      alu_a = ALU_W'({frac_q, 1'b0});
      alu_b = ~ALU_W'(pw);
      alu_c = 4'd1;
    end else begin
      alu_a = ALU_W'({src, 3'b000});
      alu_b = ALU_W'({src, 1'b0});
      alu_c = dval;
    end
    alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + (ALU_W+1)'(alu_c);
    carry   = alu_sum[ALU_W];
  end

  always_comb begin
    big  = ovf_q || ((VALUE_W'(int_q) >> (VALUE_W - 1 - FRAC_BITS)) != '0);
    comp = (VALUE_W'(int_q) << FRAC_BITS) + VALUE_W'(quo_q) + VALUE_W'(rnd_q);
  end

  // datapath
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    ovf_d   = ovf_q;
    int_d   = int_q;
    frac_d  = frac_q;
    fcnt_d  = fcnt_q;
    ch_d    = ch_q;
    has_d   = has_q;
    last_d  = last_q;
    quo_d   = quo_q;
    rnd_d   = rnd_q;
    it_d    = it_q;
    mag_d   = mag_q;
    sat_d   = sat_q;
    out_d   = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ch_d   = in_data_i.ch;
          has_d  = in_data_i.has_char;
          last_d = in_data_i.last;
        end
      end
      ST_STEP: begin
        if (has_q) begin
          unique case (phase_q)
            PH_START, PH_MINUS, PH_INT: begin
              if (is_dig) begin
                if (alu_sum[ALU_W-1:INT_BITS] != '0) begin
                  int_d = '1;
                  ovf_d = 1'b1;
                end else begin
                  int_d = alu_sum[INT_BITS-1:0];
                end
                if (phase_q == PH_MINUS) neg_d = 1'b1;
                phase_d = PH_INT;
              end else if (ch_q == CH_MINUS && phase_q == PH_START) begin
                phase_d = PH_MINUS;
              end else if (ch_q == CH_DOT && phase_q != PH_MINUS) begin
                phase_d = PH_FRAC;
              end else begin
                phase_d = PH_SKIP;
              end
            end
            PH_FRAC: begin
              if (is_dig) begin
                if (fcnt_q < FCNT_W'(MAX_FRAC_DIGITS)) begin
                  frac_d = alu_sum[FRAC_ACC_W-1:0];
                  fcnt_d = fcnt_q + FCNT_W'(1);
                end
              end else begin
                phase_d = PH_SKIP;
              end
            end
            default: ;
          endcase
        end
        it_d  = '0;
        quo_d = '0;
        rnd_d = 1'b0;
      end
      ST_DIV: begin
        if (it_q == IT_W'(FRAC_BITS)) begin
          rnd_d = carry;
        end else begin
          quo_d  = {quo_q[FRAC_BITS-2:0], carry};
          frac_d = carry ? alu_sum[FRAC_ACC_W-1:0] : FRAC_ACC_W'({frac_q, 1'b0});
        end
        it_d = it_q + IT_W'(1);
      end
      ST_FIN: begin
        if (big || comp[VALUE_W-1]) begin
          mag_d = MAG_MAX;
          sat_d = 1'b1;
        end else begin
          mag_d = comp;
          sat_d = 1'b0;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_d.value     = neg_q ? -mag_q : mag_q;
          out_d.saturated = sat_q;
          out_valid_d     = 1'b1;
          phase_d = PH_START;
          neg_d   = 1'b0;
          ovf_d   = 1'b0;
          int_d   = '0;
          frac_d  = '0;
          fcnt_d  = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_START;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      int_q       <= '0;
      frac_q      <= '0;
      fcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      neg_q       <= neg_d;
      ovf_q       <= ovf_d;
      int_q       <= int_d;
      frac_q      <= frac_d;
      fcnt_q      <= fcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    has_q  <= has_d;
    last_q <= last_d;
    quo_q  <= quo_d;
    rnd_q  <= rnd_d;
    it_q   <= it_d;
    mag_q  <= mag_d;
    sat_q  <= sat_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### design/dtf_checker.sv
// ----------------------------------------------------------------------------
// dtf_checker: port-level checks for decimal_text_to_fixed
// Output hold, one transaction at a time and result range.
// ----------------------------------------------------------------------------
module dtf_checker import dtf_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input dtf_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input dtf_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready straight after a transaction");

  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.value == MAG_MAX || out_data_o.value == NEG_MAX)
    else $error("saturated result not clamped");

  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.value != VAL_MIN)
    else $error("result outside symmetric range");

  a_short_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !in_data_i.last |=> ##1 in_ready_o)
    else $error("non-final character took more than two cycles");

endmodule

bind decimal_text_to_fixed dtf_checker u_dtf_checker (.*);

### test/decimal_text_to_fixed_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_tb: self-checking bench for the decimal text parser
// Drives character transactions with random gaps and a long output stall.
// Every string's Q31.16 result is predicted and checked field by field.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_tb;
  import dtf_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int CALM_ITEMS  = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 40;

  class fixed_parse_board;
    phase_e      phase;
    logic        negative;
    logic [63:0] int_mag;
    logic [63:0] frac_digits;
    int unsigned frac_len;
    logic        int_clamped;
    dtf_out_t    pending_values[$];
    int          errors;
    int          checked;
    int          sat_count;

    function new();
      errors    = 0;
      checked   = 0;
      sat_count = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      phase       = PH_START;
      negative    = 1'b0;
      int_mag     = '0;
      frac_digits = '0;
      frac_len    = 0;
      int_clamped = 1'b0;
    endfunction

    function void add_int_digit(logic [3:0] d);
      logic [63:0] next_mag;
      next_mag = int_mag * 64'd10 + 64'(d);
      if (next_mag > (64'd1 << INT_BITS) - 64'd1) begin
        int_mag     = (64'd1 << INT_BITS) - 64'd1;
        int_clamped = 1'b1;
      end else begin
        int_mag = next_mag;
      end
    endfunction

    function void take_item(dtf_in_t item);
      logic        dig_ok;
      logic [3:0]  d;
      logic [63:0] pw;
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] mag;
      logic        sat;
      dtf_out_t    res;
      dig_ok = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
      d      = 4'(item.ch - CH_ZERO);
      if (item.has_char) begin
        case (phase)
          PH_START: begin
            if (dig_ok) begin
              add_int_digit(d);
              phase = PH_INT;
            end else if (item.ch == CH_MINUS) phase = PH_MINUS;
            else if (item.ch == CH_DOT) phase = PH_FRAC;
            else phase = PH_SKIP;
          end
          PH_MINUS: begin
            if (dig_ok) begin
              negative = 1'b1;
              add_int_digit(d);
              phase = PH_INT;
            end else phase = PH_SKIP;
          end
          PH_INT: begin
            if (dig_ok) add_int_digit(d);
            else if (item.ch == CH_DOT) phase = PH_FRAC;
            else phase = PH_SKIP;
          end
          PH_FRAC: begin
            if (dig_ok) begin
              if (frac_len < MAX_FRAC_DIGITS) begin
                frac_digits = frac_digits * 64'd10 + 64'(d);
                frac_len++;
              end
            end else phase = PH_SKIP;
          end
          default: ;
        endcase
      end
      if (!item.last) return;

      // restoring division of the kept digits by ten to the digit count
      pw = 64'd1;
      for (int i = 0; i < frac_len; i++) pw = pw * 64'd10;
      rem = frac_digits;
      quo = '0;
      for (int i = 0; i < FRAC_BITS; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= pw) begin
          rem    = rem - pw;
          quo[0] = 1'b1;
        end
      end
      if ((rem << 1) >= pw) quo = quo + 64'd1;

      sat = int_clamped;
      if (sat || int_mag > (64'(MAG_MAX) >> FRAC_BITS)) begin
        mag = 64'(MAG_MAX);
        sat = 1'b1;
      end else begin
        mag = (int_mag << FRAC_BITS) + quo;
        if (mag > 64'(MAG_MAX)) begin
          mag = 64'(MAG_MAX);
          sat = 1'b1;
        end
      end
      if (negative) mag = 64'd0 - mag;
      res.value     = mag[VALUE_W-1:0];
      res.saturated = sat;
      if (sat) sat_count++;
      pending_values.push_back(res);
      clear_parse();
    endfunction

    function void check_value(dtf_out_t got);
      dtf_out_t want;
      if (pending_values.size() == 0) begin
        $error("result with nothing expected: value %0d saturated %0b",
               got.value, got.saturated);
        errors++;
        return;
      end
      want = pending_values.pop_front();
      checked++;
      if (got.value !== want.value) begin
        $error("value: expected %0d, actual %0d", want.value, got.value);
        errors++;
      end
      if (got.saturated !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i     = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  dtf_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  dtf_out_t out_data_o;

  fixed_parse_board board = new();

  logic [7:0] text_buf[$];
  int         items_sent   = 0;
  int         strings_sent = 0;
  bit         calm         = 1'b0;
  int         stall_cycles = 0;

  decimal_text_to_fixed DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input dtf_in_t item, input bit gaps);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_item(item);
    if (item.has_char || item.last) items_sent++;
    if (items_sent >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
    if (gaps && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic send_text(input bit tail_blank, input bit gaps, input bit blanks);
    dtf_in_t item;
    int      n;
    n = text_buf.size();
    for (int i = 0; i < n; i++) begin
      item.ch       = text_buf[i];
      item.has_char = 1'b1;
      item.last     = (i == n - 1) && !tail_blank;
      send_item(item, gaps);
      if (blanks && !item.last && $urandom_range(0, 3) == 0) begin
        item.ch       = 8'($urandom);
        item.has_char = 1'b0;
        item.last     = 1'b0;
        send_item(item, gaps);
      end
    end
    if (tail_blank || n == 0) begin
      item.ch       = 8'($urandom);
      item.has_char = 1'b0;
      item.last     = 1'b1;
      send_item(item, gaps);
    end
    strings_sent++;
  endtask

  task automatic load_text(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic push_digits(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) text_buf.push_back(CH_NINE);
      else text_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
  endtask

  // mostly well-formed numbers with random content, some noise and broken text
  task automatic make_random_text();
    int    kind;
    int    n;
    string stem;
    text_buf.delete();
    kind = $urandom_range(0, 19);
    if (kind < 2) begin
      n = $urandom_range(0, 8);
      repeat (n) text_buf.push_back(8'($urandom));
      return;
    end
    if (kind == 2) text_buf.push_back(8'($urandom));
    if ($urandom_range(0, 2) == 0) text_buf.push_back(CH_MINUS);
    if (kind == 3) begin
      stem = "214748364";
      for (int i = 0; i < stem.len(); i++) text_buf.push_back(stem[i]);
      text_buf.push_back(8'(CH_ZERO + $urandom_range(6, 9)));
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
      push_digits(n);
    end
    if ($urandom_range(0, 2) != 0) begin
      text_buf.push_back(CH_DOT);
      push_digits($urandom_range(0, 12));
    end
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 2))
        0:       text_buf.push_back(CH_MINUS);
        1:       text_buf.push_back(CH_DOT);
        default: text_buf.push_back(8'($urandom));
      endcase
      push_digits($urandom_range(0, 3));
    end
  endtask

  initial begin
    int idle_left;
    int quiet_left;
    bit held;
    idle_left  = 0;
    quiet_left = 0;
    held       = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready) board.check_value(out_data_o);
      if (!held && board.checked >= 30) begin
        // long output stall so the parser backs up onto its input
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_ready <= 1'b1;
      end else if (idle_left > 0) begin
        idle_left--;
        out_ready <= 1'b0;
      end else if (!calm && quiet_left == 0 && $urandom_range(0, 11) == 0) begin
        idle_left = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (quiet_left > 0) quiet_left--;
        else if ($urandom_range(0, 99) == 0) quiet_left = $urandom_range(50, 200);
      end
    end
  end

  initial begin
    string directed[$];
    directed = '{"", "0", "-0", "-", "-.5", "-x", ".5", ".", "-.", "123.456",
                 "-98765.4321", "0.999999999", "1.99999999999", "2147483647",
                 "-2147483647.99999", "2147483648", "99999999999", "12a34",
                 "5-3", "3.1.4", "abc"};
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      load_text(directed[i]);
      send_text(1'b0, 1'b1, 1'b0);
    end
    load_text("1.5");
    send_text(1'b1, 1'b1, 1'b1);
    text_buf.delete();
    text_buf.push_back(8'hFF);
    text_buf.push_back(CH_ZERO);
    send_text(1'b0, 1'b1, 1'b0);
    load_text("7");
    text_buf.push_back(8'h00);
    text_buf.push_back(8'h80);
    send_text(1'b0, 1'b1, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      make_random_text();
      send_text($urandom_range(0, 7) == 0, $urandom_range(0, 3) != 0,
                $urandom_range(0, 5) == 0);
    end
    in_valid <= 1'b0;

    while (board.pending_values.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d strings in %0d character transactions, %0d results checked, %0d saturated",
             strings_sent, items_sent, board.checked, board.sat_count);
    $display("signs, fraction truncation, overflow, malformed and empty text, both-side stalls");
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
